### src/efps_pkg.sv
package efps_pkg;

  // number of queues the selector looks at (mask bits above are ignored)
  localparam int NUM_QUEUES = 8;

  // field widths
  localparam int MASK_W  = 8;
  localparam int QUEUE_W = 3;
  localparam int TYPE_W  = 2;
  localparam int ERR_W   = 2;

  // occupancy bits that belong to real queues
  localparam logic [63:0] QUEUE_MASK_FULL = (64'd1 << NUM_QUEUES) - 64'd1;
  localparam logic [MASK_W-1:0] QUEUE_MASK = QUEUE_MASK_FULL[MASK_W-1:0];

  // event kinds
  localparam logic [TYPE_W-1:0] REQ_MAC     = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_ENQUEUE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_FRAME   = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_FLUSH   = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DOUBLE_REQ  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNSOLICITED = 2'd2;

  // selector outcome for one occupancy mask
  typedef struct packed {
    logic               hit;
    logic [QUEUE_W-1:0] queue;
    logic               all_empty;
    logic               express_waiting;
  } sel_t;

  // one result word, last field in the lowest bits
  typedef struct packed {
    logic               express_waiting;
    logic               all_empty;
    logic               request_open;
    logic [ERR_W-1:0]   error_code;
    logic               frame_express;
    logic               notify_upstream;
    logic [QUEUE_W-1:0] grant_queue;
    logic               grant_valid;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

### src/efps_select.sv
module efps_select import efps_pkg::*; (
  input  logic [MASK_W-1:0] nonempty,
  input  logic [MASK_W-1:0] express_mask,
  output sel_t              sel
);

  logic [MASK_W-1:0]  ex;
  logic [MASK_W-1:0]  any;
  logic [MASK_W-1:0]  pool;
  logic [QUEUE_W-1:0] top;

  // express queues first, otherwise any queue in range
  assign any  = nonempty & QUEUE_MASK;
  assign ex   = any & express_mask;
  assign pool = (ex != '0) ? ex : any;

  // highest set bit of the chosen pool
  always_comb begin
    top = '0;
    for (int q = 0; q < MASK_W; q++) begin
      if (pool[q]) begin
        top = QUEUE_W'(q);
      end
    end
  end

  assign sel.hit             = (any != '0);
  assign sel.queue           = top;
  assign sel.all_empty       = (any == '0);
  assign sel.express_waiting = (ex != '0);

endmodule

### src/express_first_priority_selection.sv
// Express-first strict-priority transmission selector for a preemption port.
// Each input word is one event: req_type in s_tuser, queue occupancy and the
// arrival queue in s_tdata. One event is accepted per clock cycle unless stalled;
// each yields exactly one result word via the input register, then the result
// register; the single-pass decode and priority encode between them sets that
// rate. The grant picks the highest-numbered nonempty express queue, else the
// highest-numbered nonempty queue. express_mask resets to zero; the user must
// write it via cfg_wr_en/cfg_wr_data only while no event is in flight (not enforced).
module express_first_priority_selection import efps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration: express_mask
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // event input
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: queue_not_empty[7:0], arrival_queue[10:8], zero fill
  input  logic [15:0] s_tdata,
  // s_tuser: req_type[1:0]
  input  logic [1:0]  s_tuser,
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: grant_valid[0], grant_queue[3:1], notify_upstream[4],
  // frame_express[5], error_code[7:6], request_open[8], all_empty[9],
  // express_waiting[10], zero fill
  output logic [15:0] m_tdata
);

  logic [MASK_W-1:0]  express_mask;
  logic               in_valid;
  logic [TYPE_W-1:0]  in_type;
  logic [MASK_W-1:0]  in_nonempty;
  logic [QUEUE_W-1:0] in_queue;
  logic               out_valid;
  result_t            out_res;
  logic               mac_request_open;
  logic               queue_request_waiting;
  logic               mac_request_open_next;
  logic               queue_request_waiting_next;
  result_t            res_next;
  sel_t               sel;
  logic               adv;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      express_mask <= '0;
    end else if (cfg_wr_en) begin
      express_mask <= cfg_wr_data;
    end
  end

  // handshake: input stage moves when result register is free or draining
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_type     <= s_tuser;
      in_nonempty <= s_tdata[7:0];
      in_queue    <= s_tdata[10:8];
    end
  end

  efps_select u_select (
    .nonempty     (in_nonempty),
    .express_mask (express_mask),
    .sel          (sel)
  );

  // event decode and flag update
  always_comb begin
    mac_request_open_next      = mac_request_open;
    queue_request_waiting_next = queue_request_waiting;
    res_next                   = '0;
    case (in_type)
      REQ_MAC: begin
        if (mac_request_open) begin
          res_next.error_code = ERR_DOUBLE_REQ;
        end else begin
          mac_request_open_next      = 1'b1;
          queue_request_waiting_next = !sel.hit;
          res_next.grant_valid       = sel.hit;
          res_next.grant_queue       = sel.hit ? sel.queue : '0;
        end
      end
      REQ_ENQUEUE: begin
        if (queue_request_waiting) begin
          queue_request_waiting_next = !sel.hit;
          res_next.grant_valid       = sel.hit;
          res_next.grant_queue       = sel.hit ? sel.queue : '0;
        end else if (!mac_request_open) begin
          res_next.notify_upstream = 1'b1;
        end
      end
      REQ_FRAME: begin
        if (!mac_request_open) begin
          res_next.error_code = ERR_UNSOLICITED;
        end else begin
          mac_request_open_next  = 1'b0;
          res_next.frame_express = (32'(in_queue) < NUM_QUEUES) && express_mask[in_queue];
        end
      end
      default: begin
        mac_request_open_next      = 1'b0;
        queue_request_waiting_next = 1'b0;
      end
    endcase
    res_next.request_open    = mac_request_open_next;
    res_next.all_empty       = sel.all_empty;
    res_next.express_waiting = sel.express_waiting;
  end

  // pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_request_open      <= 1'b0;
      queue_request_waiting <= 1'b0;
    end else if (adv) begin
      mac_request_open      <= mac_request_open_next;
      queue_request_waiting <= queue_request_waiting_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(16 - RESULT_W)'(0), out_res};

`ifndef SYNTH
  // a grant never comes out of an empty occupancy mask
  a_grant_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.grant_valid && out_res.all_empty))
    else $error("grant with all queues empty");

  // a double request leaves the request open
  a_double_req_open: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.error_code == ERR_DOUBLE_REQ) |-> out_res.request_open)
    else $error("double request reported with request closed");

  // an express tag only goes with a clean close of the request
  a_express_closes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.frame_express) |->
      (out_res.error_code == ERR_NONE && !out_res.request_open && !out_res.grant_valid))
    else $error("express tag on a bad frame event");

  // an event that advances always reaches the result register next cycle
  a_advance: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("result lost after advance");
`endif

endmodule

### sim/testbench.sv
module testbench;
  import efps_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // s_tdata: queue_not_empty[7:0], arrival_queue[10:8], zero fill
  logic [15:0] s_tdata = '0;
  // s_tuser: req_type[1:0]
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // m_tdata: grant_valid[0], grant_queue[3:1], notify_upstream[4], frame_express[5],
  // error_code[7:6], request_open[8], all_empty[9], express_waiting[10], zero fill
  logic [15:0] m_tdata;

  // selector state as the testbench sees it
  logic              pred_mac_open = 1'b0;
  logic              pred_waiting = 1'b0;
  logic [MASK_W-1:0] pred_express = '0;

  result_t expected_results[$];
  int      mismatches = 0;
  int      events_sent = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  bit      idle_on = 1'b1;

  express_first_priority_selection i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always #4 clk = ~clk;

  // express-first selection plus the request and waiting flags
  function automatic result_t predict_selection(input logic [TYPE_W-1:0] kind,
                                                input logic [MASK_W-1:0] occ_in,
                                                input logic [QUEUE_W-1:0] from_queue);
    result_t           r;
    logic [MASK_W-1:0] occ;
    logic [MASK_W-1:0] exp_occ;
    int                top;
    r = '0;
    occ = occ_in & QUEUE_MASK;
    exp_occ = occ & pred_express;
    top = -1;
    for (int q = 0; q < NUM_QUEUES; q++) if (exp_occ[q]) top = q;
    if (top < 0) begin
      for (int q = 0; q < NUM_QUEUES; q++) if (occ[q]) top = q;
    end
    case (kind)
      REQ_MAC: begin
        if (pred_mac_open) begin
          r.error_code = ERR_DOUBLE_REQ;
        end else begin
          pred_mac_open = 1'b1;
          pred_waiting = (top < 0);
          if (top >= 0) begin
            r.grant_valid = 1'b1;
            r.grant_queue = top[QUEUE_W-1:0];
          end
        end
      end
      REQ_ENQUEUE: begin
        if (pred_waiting) begin
          if (top >= 0) begin
            pred_waiting = 1'b0;
            r.grant_valid = 1'b1;
            r.grant_queue = top[QUEUE_W-1:0];
          end
        end else if (!pred_mac_open) begin
          r.notify_upstream = 1'b1;
        end
      end
      REQ_FRAME: begin
        if (!pred_mac_open) begin
          r.error_code = ERR_UNSOLICITED;
        end else begin
          pred_mac_open = 1'b0;
          if (from_queue < NUM_QUEUES) r.frame_express = pred_express[from_queue];
        end
      end
      default: begin
        pred_mac_open = 1'b0;
        pred_waiting = 1'b0;
      end
    endcase
    r.request_open = pred_mac_open;
    r.all_empty = (occ == '0);
    r.express_waiting = (exp_occ != '0);
    return r;
  endfunction

  // occupancy masks: empty, one queue, full, or anything
  function automatic logic [MASK_W-1:0] rand_occupancy();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      2: return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // present one event word, maybe after a gap, and wait for it to be taken
  task automatic send_event(input logic [TYPE_W-1:0] kind, input logic [MASK_W-1:0] occ,
                            input logic [QUEUE_W-1:0] from_queue);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, from_queue, occ};
    do @(posedge clk); while (!s_tready);
    expected_results = {expected_results, predict_selection(kind, occ, from_queue)};
    events_sent++;
  endtask

  // stop sending and let every outstanding word come back
  task automatic settle_selector();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_express_mask(input logic [MASK_W-1:0] mask);
    settle_selector();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pred_express = mask;
  endtask

  // one mac request, a few enqueues, then mostly a frame
  task automatic send_request_sequence();
    send_event(REQ_MAC, ($urandom_range(0, 2) == 0) ? '0 : rand_occupancy(),
               QUEUE_W'($urandom));
    repeat ($urandom_range(0, 3)) send_event(REQ_ENQUEUE, rand_occupancy(), QUEUE_W'($urandom));
    case ($urandom_range(0, 9))
      0: send_event(REQ_FLUSH, rand_occupancy(), QUEUE_W'($urandom));
      1: send_event(REQ_MAC, rand_occupancy(), QUEUE_W'($urandom));
      default: send_event(REQ_FRAME, rand_occupancy(), QUEUE_W'($urandom));
    endcase
  endtask

  task automatic run_random_traffic(input int n_events);
    int stop_at;
    stop_at = events_sent + n_events;
    while (events_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0)
        send_event(TYPE_W'($urandom), MASK_W'($urandom), QUEUE_W'($urandom));
      else
        send_request_sequence();
    end
  endtask

  // error paths, waiting and retry, tagging, flush, field extremes
  task automatic test_directed_events();
    write_express_mask(8'h35);
    send_event(REQ_FRAME,   8'h00, 3'd7);  // unsolicited frame
    send_event(REQ_ENQUEUE, 8'h00, 3'd0);  // no request, notify upstream
    send_event(REQ_MAC,     8'h00, 3'd0);  // opens, waits on empty queues
    send_event(REQ_MAC,     8'hFF, 3'd7);  // second request
    send_event(REQ_ENQUEUE, 8'h00, 3'd0);  // still waiting
    send_event(REQ_ENQUEUE, 8'h80, 3'd0);  // retry grants a plain queue
    send_event(REQ_ENQUEUE, 8'hFF, 3'd7);  // open but not waiting
    send_event(REQ_FRAME,   8'hFF, 3'd0);  // express tag
    send_event(REQ_MAC,     8'hFF, 3'd7);  // express queue preferred
    send_event(REQ_FRAME,   8'h00, 3'd7);  // plain frame
    send_event(REQ_MAC,     8'h00, 3'd0);
    send_event(REQ_FRAME,   8'h00, 3'd2);  // frame while still waiting
    send_event(REQ_MAC,     8'h00, 3'd0);  // request after such a frame
    send_event(REQ_ENQUEUE, 8'h0A, 3'd5);
    send_event(REQ_FLUSH,   8'hFF, 3'd7);
    send_event(REQ_MAC,     8'h00, 3'd0);
    send_event(REQ_FLUSH,   8'h00, 3'd0);
    send_event(REQ_ENQUEUE, 8'h55, 3'd3);
    send_event(REQ_FRAME,   8'hAA, 3'd4);
  endtask

  task automatic test_express_masks();
    logic [MASK_W-1:0] masks[6];
    masks = '{8'h00, 8'hFF, 8'h80, 8'h01, MASK_W'($urandom), MASK_W'($urandom)};
    foreach (masks[i]) begin
      write_express_mask(masks[i]);
      run_random_traffic(230);
    end
  endtask

  // sender holds off until the pipeline is empty, then resumes
  task automatic test_drained_pause();
    run_random_traffic(50);
    settle_selector();
    run_random_traffic(50);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    write_express_mask(MASK_W'($urandom));
    run_random_traffic(200);
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RESULT_W-1:0];
      if (expected_results.size() == 0) begin
        $display("%0t: word %h expected nothing, got %h", $time, 16'h0, m_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("grant_valid", want.grant_valid, got.grant_valid);
        check_field("grant_queue", want.grant_queue, got.grant_queue);
        check_field("notify_upstream", want.notify_upstream, got.notify_upstream);
        check_field("frame_express", want.frame_express, got.frame_express);
        check_field("error_code", want.error_code, got.error_code);
        check_field("request_open", want.request_open, got.request_open);
        check_field("all_empty", want.all_empty, got.all_empty);
        check_field("express_waiting", want.express_waiting, got.express_waiting);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_events();
    test_express_masks();
    test_drained_pause();
    test_back_to_back();
    settle_selector();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
